// ===== hw/rtl/gsrt_pkg.sv =====
// gsrt_pkg: widths, codes and shared types of the gain sag and recovery tracker
// no dependencies; imported by gsrt_mul, gsrt_core and gain_sag_recovery_tracker
package gsrt_pkg;

   localparam int TIME_BITS      = 32;
   localparam int GAIN_FRAC_BITS = 32;
   localparam int DROP_FRAC_BITS = 24;
   localparam int DECAY_BITS     = 32;

   localparam int GAIN_BITS  = GAIN_FRAC_BITS + 1;
   localparam int KEEP_BITS  = DROP_FRAC_BITS + 1;
   localparam int MUL_A_BITS = (GAIN_BITS > DECAY_BITS) ? GAIN_BITS : DECAY_BITS;
   localparam int MUL_B_BITS = (KEEP_BITS > DECAY_BITS) ? KEEP_BITS : DECAY_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   localparam logic [DECAY_BITS-1:0] DECAY_RESET = DECAY_BITS'(64'd4280079626);
   localparam logic [GAIN_BITS-1:0]  GAIN_ONE    = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
   localparam logic [KEEP_BITS-1:0]  KEEP_ONE    = {1'b1, {DROP_FRAC_BITS{1'b0}}};

   localparam logic OP_PULSE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DROP,
      ST_FINISH
   } gsrt_state_type;

   typedef enum logic {
      SHIFT_DECAY,
      SHIFT_DROP
   } gsrt_shift_type;

   typedef struct packed {
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
      gsrt_shift_type        shift_sel;
   } gsrt_mul_op_type;

   typedef struct packed {
      logic                      opcode;
      logic [TIME_BITS-1:0]      event_time;
      logic [DROP_FRAC_BITS-1:0] drop_fraction;
   } gsrt_item_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain;
      logic                 order_error;
   } gsrt_result_type;

endpackage

// ===== hw/rtl/gsrt_mul.sv =====
// gsrt_mul: the shared multiplier with its fixed-point alignment shift
// depends on gsrt_pkg; used by gsrt_core, result is registered by the caller
module gsrt_mul (
   input  gsrt_pkg::gsrt_mul_op_type            op,
   output logic [gsrt_pkg::MUL_A_BITS-1:0]      result
);
   import gsrt_pkg::*;

   logic [PROD_BITS-1:0] product;

   assign product = PROD_BITS'(op.a) * PROD_BITS'(op.b);

   // floor of the product, aligned to the fraction width of the b operand
   always_comb begin
      unique case (op.shift_sel)
         SHIFT_DECAY: result = MUL_A_BITS'(product >> DECAY_BITS);
         SHIFT_DROP:  result = MUL_A_BITS'(product >> DROP_FRAC_BITS);
         default:     result = '0;
      endcase
   end

endmodule

// ===== hw/rtl/gsrt_core.sv =====
// gsrt_core: sequencer, tracker state and working registers around one multiplier
// depends on gsrt_pkg and gsrt_mul; instantiated by gain_sag_recovery_tracker
module gsrt_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  gsrt_pkg::gsrt_item_type              item,
   input  logic [gsrt_pkg::DECAY_BITS-1:0]      decay_per_tick,
   input  logic                                 out_free,
   output logic                                 idle,
   output logic                                 done,
   output gsrt_pkg::gsrt_result_type            result
);
   import gsrt_pkg::*;

   gsrt_state_type state_ff, state_in;

   logic                      op_ff, op_in;
   logic [TIME_BITS-1:0]      time_ff, time_in;
   logic [KEEP_BITS-1:0]      keep_ff, keep_in;
   logic                      err_ff, err_in;
   logic [TIME_BITS-1:0]      elapsed_ff, elapsed_in;
   logic [DECAY_BITS-1:0]     base_ff, base_in;
   logic [GAIN_FRAC_BITS-1:0] work_d_ff, work_d_in;
   logic [GAIN_BITS-1:0]      work_g_ff, work_g_in;

   logic [GAIN_FRAC_BITS-1:0] deficit_ff, deficit_in;
   logic [TIME_BITS-1:0]      last_time_ff, last_time_in;
   logic                      pulse_seen_ff, pulse_seen_in;

   gsrt_mul_op_type        mul_op;
   logic [MUL_A_BITS-1:0]  mul_result;

   gsrt_mul u_mul (
      .op     (mul_op),
      .result (mul_result)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      time_in       = time_ff;
      keep_in       = keep_ff;
      err_in        = err_ff;
      elapsed_in    = elapsed_ff;
      base_in       = base_ff;
      work_d_in     = work_d_ff;
      work_g_in     = work_g_ff;
      deficit_in    = deficit_ff;
      last_time_in  = last_time_ff;
      pulse_seen_in = pulse_seen_ff;
      mul_op.a         = MUL_A_BITS'(work_d_ff);
      mul_op.b         = MUL_B_BITS'(base_ff);
      mul_op.shift_sel = SHIFT_DECAY;
      idle = 1'b0;
      done = 1'b0;
      result.gain        = err_ff ? '0 : work_g_ff;
      result.order_error = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               op_in      = item.opcode;
               time_in    = item.event_time;
               keep_in    = KEEP_ONE - KEEP_BITS'(item.drop_fraction);
               err_in     = item.event_time < last_time_ff;
               // no recovery before the first pulse
               elapsed_in = pulse_seen_ff ? item.event_time - last_time_ff : '0;
               base_in    = decay_per_tick;
               work_d_in  = deficit_ff;
               state_in   = (item.event_time < last_time_ff) ? ST_FINISH : ST_STEP;
            end
         end
         ST_STEP: begin
            // square-and-multiply, lsb first, one product per cycle
            if (elapsed_ff == '0) begin
               work_g_in = GAIN_ONE - GAIN_BITS'(work_d_ff);
               state_in  = (op_ff == OP_PULSE) ? ST_DROP : ST_FINISH;
            end else if (elapsed_ff[0]) begin
               mul_op.a   = MUL_A_BITS'(work_d_ff);
               mul_op.b   = MUL_B_BITS'(base_ff);
               work_d_in  = GAIN_FRAC_BITS'(mul_result);
               elapsed_in = {elapsed_ff[TIME_BITS-1:1], 1'b0};
            end else begin
               mul_op.a   = MUL_A_BITS'(base_ff);
               mul_op.b   = MUL_B_BITS'(base_ff);
               base_in    = DECAY_BITS'(mul_result);
               elapsed_in = elapsed_ff >> 1;
            end
         end
         ST_DROP: begin
            mul_op.a         = MUL_A_BITS'(work_g_ff);
            mul_op.b         = MUL_B_BITS'(keep_ff);
            mul_op.shift_sel = SHIFT_DROP;
            work_g_in        = GAIN_BITS'(mul_result);
            state_in         = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               if (!err_ff && op_ff == OP_PULSE) begin
                  // a gain of zero would need a deficit of one: saturate
                  deficit_in    = (work_g_ff == '0) ? '1
                                                    : GAIN_FRAC_BITS'(GAIN_ONE - work_g_ff);
                  last_time_in  = time_ff;
                  pulse_seen_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         deficit_ff    <= '0;
         last_time_ff  <= '0;
         pulse_seen_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         deficit_ff    <= deficit_in;
         last_time_ff  <= last_time_in;
         pulse_seen_ff <= pulse_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      time_ff    <= time_in;
      keep_ff    <= keep_in;
      err_ff     <= err_in;
      elapsed_ff <= elapsed_in;
      base_ff    <= base_in;
      work_d_ff  <= work_d_in;
      work_g_ff  <= work_g_in;
   end

`ifndef SYNTHESIS
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && idle |=> !idle)
      else $error("core still idle after taking a word");

   a_err_zero_gain: assert property (@(posedge clock) disable iff (reset)
      done && result.order_error |-> result.gain == '0)
      else $error("out-of-order word reports nonzero gain");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> last_time_ff >= $past(last_time_ff))
      else $error("last pulse time moved backward");

   a_elapsed_shrinks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && state_ff == ST_STEP && $past(state_ff) == ST_STEP
      |-> elapsed_ff < $past(elapsed_ff))
      else $error("exponent walk made no progress");

   a_no_deficit_before_pulse: assert property (@(posedge clock) disable iff (reset)
      !pulse_seen_ff |-> deficit_ff == '0)
      else $error("deficit nonzero before first pulse");
`endif

endmodule

// ===== hw/rtl/gain_sag_recovery_tracker.sv =====
// gain_sag_recovery_tracker: top level with register port, request intake and
// result register; depends on gsrt_pkg and gsrt_core
//
// usage:
//  req_ channel takes one word per item: opcode (pulse or query), event time in
//  ticks and, for a pulse, the relative drop. each word yields exactly one rsp_
//  word: the gain in unsigned Q1.32 and an order_error flag.
//  csr_ channel writes decay_per_tick (Q0.32); write it only while no word is
//  in flight. csr_ready is always high.
//  the exponent walk multiplies the deficit by the decay per set bit of the
//  elapsed time and squares the decay per bit below its top set bit, then a
//  closing step forms the gain; a pulse adds its drop step, and a hand-off step
//  follows. an out-of-order word skips the walk and goes to the hand-off. the
//  core has a single shared multiplier and takes no new word until the last is
//  through; req_ready is low while a word is worked.
//  a finished result sits in the output register; if rsp_ready is low the core
//  holds its result and takes no new word until the register frees.
//  reset: decay_per_tick returns to its default, the gain to one (no pulse
//  seen), last pulse time to zero, and the output register empties.
module gain_sag_recovery_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [gsrt_pkg::TIME_BITS-1:0]       req_event_time,
   input  logic [gsrt_pkg::DROP_FRAC_BITS-1:0]  req_drop_fraction,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gsrt_pkg::GAIN_BITS-1:0]       rsp_gain,
   output logic                                 rsp_order_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsrt_pkg::DECAY_BITS-1:0]      csr_decay_per_tick
);
   import gsrt_pkg::*;

   logic [DECAY_BITS-1:0] decay_ff, decay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gsrt_result_type       rsp_word_ff, rsp_word_in;

   gsrt_item_type   item;
   gsrt_result_type core_result;
   logic            core_idle;
   logic            core_done;
   logic            out_free;

   assign item.opcode        = req_opcode;
   assign item.event_time    = req_event_time;
   assign item.drop_fraction = req_drop_fraction;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = core_idle;
   assign csr_ready = 1'b1;

   gsrt_core u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (req_valid && core_idle),
      .item           (item),
      .decay_per_tick (decay_ff),
      .out_free       (out_free),
      .idle           (core_idle),
      .done           (core_done),
      .result         (core_result)
   );

   always_comb begin
      decay_in     = csr_valid ? csr_decay_per_tick : decay_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         decay_ff     <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gain        = rsp_word_ff.gain;
   assign rsp_order_error = rsp_word_ff.order_error;

endmodule
